[design/cdsr_pkg.sv]
// Shared constants, types and DAC step functions for the charger DAC step regulator.
package cdsr_pkg;

    localparam int FINE_ROLL   = 31;
    localparam int SAMPLE_BITS = 10;

    localparam int COARSE_W = 8;
    localparam int FINE_W   = 5;
    localparam int CCNT_W   = 5;
    localparam int VCNT_W   = 4;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam int BAND_ABOVE = 2;
    localparam int CURR_HOLD  = 20;
    localparam int VOLT_PASS  = 10;

    // opcodes
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ON       = 3'd1;
    localparam logic [2:0] OP_OFF      = 3'd2;
    localparam logic [2:0] OP_ARM_CURR = 3'd3;
    localparam logic [2:0] OP_ARM_VOLT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_CEILING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_START   = 1'd1;

    typedef struct packed {
        logic [COARSE_W-1:0] coarse;
        logic [FINE_W-1:0]   fine;
    } dac_t;

    typedef struct packed {
        logic [2:0]             opcode;
        logic [SAMPLE_BITS-1:0] target_level;
        logic [SAMPLE_BITS-1:0] measured_current;
        logic [SAMPLE_BITS-1:0] measured_voltage;
    } item_t;

    typedef struct packed {
        logic [COARSE_W-1:0] coarse_code;
        logic [FINE_W-1:0]   fine_code;
        logic                output_is_on;
        logic                current_armed;
        logic                voltage_armed;
        logic                current_settled_flag;
        logic                voltage_settled_flag;
    } result_t;

    // one step up; frozen at or above the ceiling
    function automatic dac_t dac_up(input dac_t d, input logic [COARSE_W-1:0] ceiling);
        dac_t r;
        r = d;
        if (d.coarse < ceiling) begin
            if (d.fine >= FINE_W'(FINE_ROLL)) begin
                r.fine   = '0;
                r.coarse = d.coarse + COARSE_W'(1);
            end
            else begin
                r.fine = d.fine + FINE_W'(1);
            end
        end
        return r;
    endfunction

    // one step down; frozen at coarse 0 / fine 0
    function automatic dac_t dac_down(input dac_t d);
        dac_t r;
        r = d;
        if (d.fine == '0) begin
            if (d.coarse != '0) begin
                r.fine   = FINE_W'(FINE_ROLL);
                r.coarse = d.coarse - COARSE_W'(1);
            end
        end
        else begin
            r.fine = d.fine - FINE_W'(1);
        end
        return r;
    endfunction

endpackage

[design/charger_dac_step_regulator_top.sv]
// Top level of the charger DAC step regulator: stream ports and two-entry result buffer.
// Each accepted result is registered into the head entry, or into the skid entry when
// the head is full and not popped; the head drives m_tvalid. Throughput: one transaction
// per cycle while s_tready is high; s_tready is low while the skid entry is full.
// A two-entry result buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst_n low, asynchronous): DAC, modes, targets, counts and flags clear,
//   coarse_ceiling = 63, coarse_start = 0, result buffer empty.
module charger_dac_step_regulator_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [cdsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdsr_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [9:0] target_level, [19:10] measured_current,
                                  // [29:20] measured_voltage, [31:30] zero
    input  logic [2:0]  s_tuser,  // [2:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [7:0] coarse_code, [12:8] fine_code, [13] output_is_on,
                                  // [14] current_armed, [15] voltage_armed,
                                  // [16] current_settled_flag, [17] voltage_settled_flag,
                                  // [23:18] zero
);
    import cdsr_pkg::*;

    item_t   item;
    result_t result;
    logic    push;
    logic    pop;

    // result buffer: head drives the port, skid catches one extra transaction
    logic    head_valid_reg, head_valid_next;
    result_t head_reg, head_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    assign item.opcode           = s_tuser;
    assign item.target_level     = s_tdata[9:0];
    assign item.measured_current = s_tdata[19:10];
    assign item.measured_voltage = s_tdata[29:20];

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = head_valid_reg && m_tready;

    cdsr_regulator u_regulator (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (push),
        .item        (item),
        .result      (result)
    );

    always_comb begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                // no push possible here: s_tready is low while skid is full
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else begin
                head_valid_next = push;
                head_next       = result;
            end
        end
        else if (push) begin
            if (!head_valid_reg) begin
                head_valid_next = 1'b1;
                head_next       = result;
            end
            else begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {6'd0,
                       head_reg.voltage_settled_flag,
                       head_reg.current_settled_flag,
                       head_reg.voltage_armed,
                       head_reg.current_armed,
                       head_reg.output_is_on,
                       head_reg.fine_code,
                       head_reg.coarse_code};

    // skid entry is only ever filled behind a full head
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with empty head");

    a_fine_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[12:8] <= FINE_W'(FINE_ROLL)))
        else $error("fine code beyond roll value");

    // with the output off nothing can step the DAC away from zero
    a_off_dac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[13]) |-> (m_tdata[12:0] == 13'd0))
        else $error("DAC nonzero while output off");

    a_settled_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((!m_tdata[16] || m_tdata[14]) && (!m_tdata[17] || m_tdata[15])))
        else $error("settled flag set on a disarmed mode");

endmodule

[design/cdsr_regulator.sv]
// Regulator state, configuration registers and per-item next-state logic.
module cdsr_regulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cdsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdsr_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          item_accept,
    input  cdsr_pkg::item_t               item,
    output cdsr_pkg::result_t             result
);
    import cdsr_pkg::*;

    logic [COARSE_W-1:0]    ceiling_reg;
    logic [COARSE_W-1:0]    start_reg;

    dac_t                   dac_reg, dac_next;
    logic                   en_reg, en_next;
    logic                   cur_on_reg, cur_on_next;
    logic                   vol_on_reg, vol_on_next;
    logic [SAMPLE_BITS-1:0] cur_tgt_reg, cur_tgt_next;
    logic [SAMPLE_BITS-1:0] vol_tgt_reg, vol_tgt_next;
    logic [CCNT_W-1:0]      cur_cnt_reg, cur_cnt_next;
    logic [VCNT_W-1:0]      vol_cnt_reg, vol_cnt_next;
    logic                   cur_set_reg, cur_set_next;
    logic                   vol_set_reg, vol_set_next;

    logic [VCNT_W-1:0]      vol_cnt_inc;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ceiling_reg <= COARSE_W'(63);
            start_reg   <= '0;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_COARSE_CEILING: ceiling_reg <= cfg_data;
                CFG_COARSE_START:   start_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dac_next     = dac_reg;
        en_next      = en_reg;
        cur_on_next  = cur_on_reg;
        vol_on_next  = vol_on_reg;
        cur_tgt_next = cur_tgt_reg;
        vol_tgt_next = vol_tgt_reg;
        cur_cnt_next = cur_cnt_reg;
        vol_cnt_next = vol_cnt_reg;
        cur_set_next = cur_set_reg;
        vol_set_next = vol_set_reg;
        vol_cnt_inc  = vol_cnt_reg + VCNT_W'(1);

        case (item.opcode)
            OP_TICK: begin
                // current loop first
                if (en_reg && cur_on_reg) begin
                    if (item.measured_current < cur_tgt_reg) begin
                        dac_next = dac_up(dac_next, ceiling_reg);
                    end
                    else if ({1'b0, item.measured_current} >
                             ({1'b0, cur_tgt_reg} + (SAMPLE_BITS+1)'(BAND_ABOVE))) begin
                        dac_next = dac_down(dac_next);
                    end
                    else if (cur_cnt_reg < CCNT_W'(CURR_HOLD)) begin
                        cur_cnt_next = cur_cnt_reg + CCNT_W'(1);
                    end
                    else begin
                        cur_set_next = 1'b1;
                    end
                end
                else begin
                    cur_tgt_next = '0;
                    cur_cnt_next = '0;
                    cur_on_next  = 1'b0;
                    cur_set_next = 1'b0;
                end
                // then voltage loop, on the DAC the current loop left
                if (en_reg && vol_on_reg) begin
                    if (item.measured_voltage < vol_tgt_reg) begin
                        dac_next = dac_up(dac_next, ceiling_reg);
                    end
                    else if ({1'b0, item.measured_voltage} >
                             ({1'b0, vol_tgt_reg} + (SAMPLE_BITS+1)'(BAND_ABOVE))) begin
                        dac_next = dac_down(dac_next);
                    end
                    else if (vol_cnt_inc > VCNT_W'(VOLT_PASS)) begin
                        vol_set_next = 1'b1;
                        vol_cnt_next = '0;
                    end
                    else begin
                        vol_cnt_next = vol_cnt_inc;
                    end
                end
                else begin
                    vol_tgt_next = '0;
                    vol_cnt_next = '0;
                    vol_on_next  = 1'b0;
                    vol_set_next = 1'b0;
                end
            end
            OP_ON: begin
                dac_next.coarse = start_reg;
                dac_next.fine   = '0;
                en_next         = 1'b1;
            end
            OP_OFF: begin
                dac_next = '0;
                en_next  = 1'b0;
            end
            OP_ARM_CURR: begin
                cur_tgt_next = item.target_level;
                cur_on_next  = 1'b1;
            end
            OP_ARM_VOLT: begin
                vol_tgt_next = item.target_level;
                vol_on_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dac_reg     <= '0;
            en_reg      <= 1'b0;
            cur_on_reg  <= 1'b0;
            vol_on_reg  <= 1'b0;
            cur_tgt_reg <= '0;
            vol_tgt_reg <= '0;
            cur_cnt_reg <= '0;
            vol_cnt_reg <= '0;
            cur_set_reg <= 1'b0;
            vol_set_reg <= 1'b0;
        end
        else if (item_accept) begin
            dac_reg     <= dac_next;
            en_reg      <= en_next;
            cur_on_reg  <= cur_on_next;
            vol_on_reg  <= vol_on_next;
            cur_tgt_reg <= cur_tgt_next;
            vol_tgt_reg <= vol_tgt_next;
            cur_cnt_reg <= cur_cnt_next;
            vol_cnt_reg <= vol_cnt_next;
            cur_set_reg <= cur_set_next;
            vol_set_reg <= vol_set_next;
        end
    end

    assign result.coarse_code          = dac_next.coarse;
    assign result.fine_code            = dac_next.fine;
    assign result.output_is_on         = en_next;
    assign result.current_armed        = cur_on_next;
    assign result.voltage_armed        = vol_on_next;
    assign result.current_settled_flag = cur_set_next;
    assign result.voltage_settled_flag = vol_set_next;

endmodule
